// ===== hdl/iprt_pkg.sv =====
// ----------------------------------------------------------------------------
// iprt_pkg
// Shared types and constants of the address range table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package iprt_pkg;

  localparam int ADDR_W  = 32;
  localparam int ENTRY_W = 10;
  localparam int CFG_W   = 11;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  // a holds the range start of a load or the address of a lookup
  typedef struct packed {
    kind_t               kind;
    logic [ENTRY_W-1:0]  index;
    logic [ADDR_W-1:0]   a;
    logic [ADDR_W-1:0]   b;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fb_req_t;

endpackage

`default_nettype wire

// ===== hdl/iprt_ram.sv =====
// ----------------------------------------------------------------------------
// iprt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module iprt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/iprt_front.sv =====
// ----------------------------------------------------------------------------
// iprt_front
// Accepts items, drops loads outside the table and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module iprt_front import iprt_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [ENTRY_W-1:0] entry_index,
  input  wire logic [ADDR_W-1:0]  range_start,
  input  wire logic [ADDR_W-1:0]  range_end,
  input  wire logic [ADDR_W-1:0]  lookup_address,
  output fb_req_t                 req,
  input  wire logic               req_ready
);

  item_t              queue [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  item_t              item_in;
  logic               load_ok;
  logic               push;
  logic               pop;

  assign in_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign load_ok  = (32'(entry_index) < 32'(TABLE_DEPTH));

  always_comb begin
    item_in.kind  = (kind == KIND_LOOKUP) ? KIND_LOOKUP : KIND_LOAD;
    item_in.index = entry_index;
    item_in.a     = (kind == KIND_LOOKUP) ? lookup_address : range_start;
    item_in.b     = range_end;
  end

  // loads beyond the table are accepted and dropped here
  assign push = in_valid && in_ready && ((kind == KIND_LOOKUP) || load_ok);
  assign pop  = req.valid && req_ready;

  assign req = '{valid: (count != '0), item: queue[rd_ptr]};

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/iprt_back.sv =====
// ----------------------------------------------------------------------------
// iprt_back
// Executes queued items: writes table entries and runs the binary search.
// ----------------------------------------------------------------------------
`default_nettype none

module iprt_back import iprt_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fb_req_t            req,
  output logic                    req_ready,
  input  wire logic [CNT_W-1:0]   active_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic      [ENTRY_W-1:0] match_index,
  output logic      [ADDR_W-1:0]  match_start,
  output logic      [ADDR_W-1:0]  match_end
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STEP  = 4'b0010,
    S_CHECK = 4'b0100,
    S_FETCH = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  lo_next;
  logic [CNT_W-1:0]  left;
  logic [CNT_W-1:0]  left_next;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  lo_step;
  logic [CNT_W-1:0]  left_step;
  logic              below;
  logic              exact;
  logic              in_range;
  logic              out_free;
  logic              wr_en;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [ADDR_W-1:0] start_rd;
  logic [ADDR_W-1:0] end_rd;
  logic              emit;
  logic              emit_hit;

  iprt_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_start_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(req.item.index)),
    .wr_data (req.item.a),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (start_rd)
  );

  iprt_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_end_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(req.item.index)),
    .wr_data (req.item.b),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (end_rd)
  );

  always_comb begin
    half      = left >> 1;
    mid       = lo + half;
    below     = (start_rd < addr);
    lo_step   = below ? mid + CNT_W'(1) : lo;
    left_step = below ? left - half - CNT_W'(1) : half;
    exact     = (lo != active_count) && (start_rd == addr);
    in_range  = (start_rd <= addr) && (addr <= end_rd);
    out_free  = !out_valid || out_ready;

    state_next = state;
    lo_next    = lo;
    left_next  = left;
    req_ready  = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    emit       = 1'b0;
    emit_hit   = 1'b0;

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          if (req.item.kind == KIND_LOAD) begin
            wr_en = 1'b1;
          end else begin
            lo_next   = '0;
            left_next = active_count;
            if (active_count != '0) begin
              rd_en      = 1'b1;
              rd_addr    = IDX_W'(active_count >> 1);
              state_next = S_STEP;
            end else begin
              state_next = S_CHECK;
            end
          end
        end
      end
      S_STEP: begin
        lo_next   = lo_step;
        left_next = left_step;
        if (left_step != '0) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(lo_step + (left_step >> 1));
        end else begin
          // probe the lower bound itself for an exact start match
          if (lo_step != active_count) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(lo_step);
          end
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (exact) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_hit   = in_range;
            state_next = S_IDLE;
          end
        end else if (lo == '0) begin
          if (out_free) begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = IDX_W'(lo - CNT_W'(1));
          lo_next    = lo - CNT_W'(1);
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_hit   = in_range;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo   <= lo_next;
    left <= left_next;
    if (state == S_IDLE && req.valid && req.item.kind == KIND_LOOKUP) begin
      addr <= req.item.a;
    end
    if (emit) begin
      hit         <= emit_hit;
      match_index <= emit_hit ? ENTRY_W'(lo) : '0;
      match_start <= emit_hit ? start_rd : '0;
      match_end   <= emit_hit ? end_rd : '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ip_range_table_lookup.sv =====
// lookup: s search steps through the start table, s = search steps
// (s <= ceil(log2(range_count + 1))), then a check, plus a fetch of the entry below
// the lower bound when no start matches exactly; out_ready stalls hold the result
// one lookup is searched at a time over the single read port of the start table;
// loads retire one per cycle while no lookup is in progress
// reset clears the range count, the item queue, the search state and out_valid;
// table contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// ip_range_table_lookup
// Sorted address range table with binary-search lookup behind an item queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_range_table_lookup import iprt_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_range_count,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [ENTRY_W-1:0] entry_index,
  input  wire logic [ADDR_W-1:0]  range_start,
  input  wire logic [ADDR_W-1:0]  range_end,
  input  wire logic [ADDR_W-1:0]  lookup_address,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic      [ENTRY_W-1:0] match_index,
  output logic      [ADDR_W-1:0]  match_start,
  output logic      [ADDR_W-1:0]  match_end
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0] range_count;
  fb_req_t          req;
  logic             req_ready;

  assign cfg_ready = 1'b1;

  // count saturates at the table depth
  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (32'(cfg_range_count) > 32'(TABLE_DEPTH)) begin
        range_count <= CNT_W'(TABLE_DEPTH);
      end else begin
        range_count <= CNT_W'(cfg_range_count);
      end
    end
  end

  iprt_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .entry_index    (entry_index),
    .range_start    (range_start),
    .range_end      (range_end),
    .lookup_address (lookup_address),
    .req            (req),
    .req_ready      (req_ready)
  );

  iprt_back #(.TABLE_DEPTH(TABLE_DEPTH), .CNT_W(CNT_W)) u_back (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .req_ready    (req_ready),
    .active_count (range_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .match_index  (match_index),
    .match_start  (match_start),
    .match_end    (match_end)
  );

endmodule

`default_nettype wire

// ===== hdl/iprt_checker.sv =====
// ----------------------------------------------------------------------------
// iprt_checker
// Port-level checks of the range table lookup, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iprt_checker import iprt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               hit,
  input wire logic [ENTRY_W-1:0] match_index,
  input wire logic [ADDR_W-1:0]  match_start,
  input wire logic [ADDR_W-1:0]  match_end
);

  // a result held back keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(match_index)
      && $stable(match_start) && $stable(match_end))
    else $error("result changed while stalled");

  // a miss reports all-zero match fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> match_index == '0 && match_start == '0 && match_end == '0)
    else $error("miss with nonzero match fields");

  // a hit range is never inverted
  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> match_start <= match_end)
    else $error("hit on an inverted range");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ip_range_table_lookup iprt_checker u_iprt_checker (.*);

`default_nettype wire
